/* src/cc_pkg.sv */
// Shared widths, command and status types for the coprime range counter.
`timescale 1ns / 1ps
package cc_pkg;

  localparam int VALUE_BITS          = 50;
  localparam int MODULUS_BITS        = 30;
  localparam int MAX_DISTINCT_PRIMES = 9;

  // Divider width covers both a value and a modulus as dividend
  localparam int DIV_BITS  = (VALUE_BITS > MODULUS_BITS) ? VALUE_BITS : MODULUS_BITS;
  localparam int DCNT_BITS = $clog2(DIV_BITS + 1);
  // Trial divisor width: half the modulus width, rounded up, plus one
  localparam int TRIAL_BITS = (MODULUS_BITS + 1) / 2 + 1;
  localparam int PCNT_BITS  = $clog2(MAX_DISTINCT_PRIMES + 1);
  localparam int PIDX_BITS  = (MAX_DISTINCT_PRIMES > 1) ? $clog2(MAX_DISTINCT_PRIMES) : 1;
  localparam int SUBSET_BITS = MAX_DISTINCT_PRIMES + 1;

  localparam int IN_BITS  = 2 * VALUE_BITS + MODULUS_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VALUE_BITS + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    DIV_TRIAL = 2'd0,
    DIV_HIGH  = 2'd1,
    DIV_LOW   = 2'd2
  } div_op_t;

  typedef struct packed {
    logic    load;        // capture input item
    logic    trial_init;  // divisor 2, clear primes
    logic    d_inc;       // next trial divisor
    logic    div_start;
    div_op_t div_op;
    logic    add_d;       // record trial divisor as prime
    logic    take_q;      // residual modulus becomes quotient
    logic    add_m;       // record leftover factor as prime
    logic    sum_init;    // start inclusion-exclusion sum
    logic    prod_init;   // start subset product
    logic    prod_step;   // fold in one prime
    logic    acc_high;    // apply high quotient
    logic    acc_low;     // apply low quotient
    logic    subset_inc;
    logic    out_load;    // write result register
    logic    out_direct;  // result from closed form, not from sum
  } cmd_t;

  typedef struct packed {
    logic rev;        // low above high
    logic n_zero;
    logic n_one;
    logic sq_gt;      // d*d above residual
    logic rem_zero;
    logic m_gt1;
    logic div_done;
    logic j_end;
    logic subset_end;
    logic out_free;
  } sts_t;

endpackage

/* src/cc_div.sv */
// Restoring divider, one quotient bit per cycle, short or long dividend.
`timescale 1ns / 1ps
module cc_div
  import cc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    long_op,
  input  logic [DIV_BITS-1:0]     dividend,
  input  logic [MODULUS_BITS-1:0] divisor,
  output logic                    done,
  output logic [DIV_BITS-1:0]     quotient,
  output logic [MODULUS_BITS-1:0] remainder
);

  logic [DIV_BITS-1:0]     q_r;
  logic [MODULUS_BITS-1:0] rem_r, dsr_r;
  logic [DCNT_BITS-1:0]    cnt_r;
  logic                    busy_r, done_r;
  logic [MODULUS_BITS:0]   rem_sh, diff;
  logic                    fits;

  assign rem_sh = {rem_r, q_r[DIV_BITS-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DCNT_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // short operands sit at the top so MODULUS_BITS steps suffice
      q_r   <= long_op ? dividend : (dividend << (DIV_BITS - MODULUS_BITS));
      rem_r <= '0;
      dsr_r <= divisor;
      cnt_r <= long_op ? DCNT_BITS'(DIV_BITS) : DCNT_BITS'(MODULUS_BITS);
    end else if (busy_r) begin
      rem_r <= fits ? diff[MODULUS_BITS-1:0] : rem_sh[MODULUS_BITS-1:0];
      q_r   <= {q_r[DIV_BITS-2:0], fits};
      cnt_r <= cnt_r - DCNT_BITS'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* src/cc_dp.sv */
// Datapath: operand registers, prime list, subset product, sum and result register.
`timescale 1ns / 1ps
module cc_dp
  import cc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  logic [VALUE_BITS-1:0]   low_r, high_r, x2_r, acc_r, count_r;
  logic [MODULUS_BITS-1:0] m_r, prod_r;
  logic [MODULUS_BITS-1:0] primes_r [MAX_DISTINCT_PRIMES];
  logic [TRIAL_BITS-1:0]   d_r;
  logic [PCNT_BITS-1:0]    pcnt_r, j_r;
  logic [SUBSET_BITS-1:0]  subset_r;
  logic                    par_r, err_r, ovalid_r;

  logic [2*TRIAL_BITS-1:0]   d_sq;
  logic [2*MODULUS_BITS-1:0] prod_full;
  logic [DIV_BITS-1:0]       div_a, div_q;
  logic [MODULUS_BITS-1:0]   div_b, div_rem;
  logic                      div_long, div_done;
  logic [VALUE_BITS-1:0]     qv, direct;
  logic                      pc_room;

  assign d_sq      = d_r * d_r;
  assign prod_full = prod_r * primes_r[j_r[PIDX_BITS-1:0]];
  assign qv        = div_q[VALUE_BITS-1:0];
  assign pc_room   = pcnt_r < PCNT_BITS'(MAX_DISTINCT_PRIMES);

  always_comb begin
    div_a    = DIV_BITS'(m_r);
    div_b    = MODULUS_BITS'(d_r);
    div_long = 1'b0;
    unique case (cmd.div_op)
      DIV_TRIAL: begin
        div_a = DIV_BITS'(m_r);
        div_b = MODULUS_BITS'(d_r);
      end
      DIV_HIGH: begin
        div_a    = DIV_BITS'(high_r);
        div_b    = prod_r;
        div_long = 1'b1;
      end
      DIV_LOW: begin
        div_a    = DIV_BITS'(x2_r);
        div_b    = prod_r;
        div_long = 1'b1;
      end
      default: ;
    endcase
  end

  cc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .long_op   (div_long),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // closed form for modulus zero or one
  always_comb begin
    if (m_r == '0) begin
      direct = VALUE_BITS'(low_r <= VALUE_BITS'(1) && high_r >= VALUE_BITS'(1));
    end else if (low_r == '0) begin
      direct = (high_r == VMAX) ? VMAX : high_r + VALUE_BITS'(1);
    end else begin
      direct = high_r - low_r + VALUE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low_r  <= in_tdata[VALUE_BITS-1:0];
      high_r <= in_tdata[2*VALUE_BITS-1:VALUE_BITS];
      m_r    <= in_tdata[IN_BITS-1:2*VALUE_BITS];
    end
    if (cmd.trial_init) begin
      d_r    <= TRIAL_BITS'(2);
      x2_r   <= (low_r == '0) ? '0 : low_r - VALUE_BITS'(1);
    end
    if (cmd.d_inc) d_r <= d_r + TRIAL_BITS'(1);
    if (cmd.take_q) m_r <= div_q[MODULUS_BITS-1:0];
    if ((cmd.add_d || cmd.add_m) && pc_room) begin
      primes_r[pcnt_r[PIDX_BITS-1:0]] <= cmd.add_d ? MODULUS_BITS'(d_r) : m_r;
    end
    if (cmd.sum_init) begin
      acc_r    <= high_r - x2_r;
      subset_r <= SUBSET_BITS'(1);
    end
    if (cmd.prod_init) begin
      prod_r <= MODULUS_BITS'(1);
      j_r    <= '0;
      par_r  <= 1'b0;
    end
    if (cmd.prod_step) begin
      if (subset_r[j_r]) begin
        prod_r <= prod_full[MODULUS_BITS-1:0];
        par_r  <= ~par_r;
      end
      j_r <= j_r + PCNT_BITS'(1);
    end
    if (cmd.acc_high) acc_r <= par_r ? acc_r - qv : acc_r + qv;
    if (cmd.acc_low)  acc_r <= par_r ? acc_r + qv : acc_r - qv;
    if (cmd.subset_inc) subset_r <= subset_r + SUBSET_BITS'(1);
    if (cmd.out_load) begin
      err_r   <= low_r > high_r;
      count_r <= (low_r > high_r) ? '0 : (cmd.out_direct ? direct : acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.trial_init) begin
        pcnt_r <= '0;
      end else if ((cmd.add_d || cmd.add_m) && pc_room) begin
        pcnt_r <= pcnt_r + PCNT_BITS'(1);
      end
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign sts.rev        = low_r > high_r;
  assign sts.n_zero     = m_r == '0;
  assign sts.n_one      = m_r == MODULUS_BITS'(1);
  assign sts.sq_gt      = d_sq > (2*TRIAL_BITS)'(m_r);
  assign sts.rem_zero   = div_rem == '0;
  assign sts.m_gt1      = m_r > MODULUS_BITS'(1);
  assign sts.div_done   = div_done;
  assign sts.j_end      = j_r == pcnt_r;
  assign sts.subset_end = subset_r == (SUBSET_BITS'(1) << pcnt_r);
  assign sts.out_free   = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_W'({err_r, count_r});

endmodule

/* src/cc_ctrl.sv */
// Controller: sequences factoring, subset sums and result hand-off.
`timescale 1ns / 1ps
module cc_ctrl
  import cc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_CLASS   = 15'b000000000000010,
    S_FIN_D   = 15'b000000000000100,
    S_TRIAL   = 15'b000000000001000,
    S_TRIAL_W = 15'b000000000010000,
    S_STRIP   = 15'b000000000100000,
    S_STRIP_W = 15'b000000001000000,
    S_TAIL    = 15'b000000010000000,
    S_SUBSET  = 15'b000000100000000,
    S_PROD    = 15'b000001000000000,
    S_DIVH    = 15'b000010000000000,
    S_DIVH_W  = 15'b000100000000000,
    S_DIVL    = 15'b001000000000000,
    S_DIVL_W  = 15'b010000000000000,
    S_FIN     = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_op = DIV_TRIAL;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.trial_init = 1'b1;
        if (sts.rev || sts.n_zero || sts.n_one) state_nxt = S_FIN_D;
        else state_nxt = S_TRIAL;
      end
      S_FIN_D: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_direct = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TRIAL: begin
        if (sts.sq_gt) begin
          state_nxt = S_TAIL;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_TRIAL_W;
        end
      end
      S_TRIAL_W: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.add_d  = 1'b1;
            cmd.take_q = 1'b1;
            state_nxt  = S_STRIP;
          end else begin
            cmd.d_inc = 1'b1;
            state_nxt = S_TRIAL;
          end
        end
      end
      S_STRIP: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_STRIP_W;
      end
      S_STRIP_W: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.take_q = 1'b1;
            state_nxt  = S_STRIP;
          end else begin
            cmd.d_inc = 1'b1;
            state_nxt = S_TRIAL;
          end
        end
      end
      S_TAIL: begin
        // keep a leftover factor above the square root
        cmd.add_m    = sts.m_gt1;
        cmd.sum_init = 1'b1;
        state_nxt    = S_SUBSET;
      end
      S_SUBSET: begin
        if (sts.subset_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.prod_init = 1'b1;
          state_nxt     = S_PROD;
        end
      end
      S_PROD: begin
        if (sts.j_end) state_nxt = S_DIVH;
        else cmd.prod_step = 1'b1;
      end
      S_DIVH: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_HIGH;
        state_nxt     = S_DIVH_W;
      end
      S_DIVH_W: begin
        cmd.div_op = DIV_HIGH;
        if (sts.div_done) begin
          cmd.acc_high = 1'b1;
          state_nxt    = S_DIVL;
        end
      end
      S_DIVL: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_LOW;
        state_nxt     = S_DIVL_W;
      end
      S_DIVL_W: begin
        cmd.div_op = DIV_LOW;
        if (sts.div_done) begin
          cmd.acc_low    = 1'b1;
          cmd.subset_inc = 1'b1;
          state_nxt      = S_SUBSET;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* src/coprime_count_in_range.sv */
// Top level of the coprime range counter.
// One item at a time: an item gives the count of integers in range_low..range_high that share
// no factor with modulus. Time per item is set by the one shared restoring divider (one
// quotient bit per cycle): trial division divides by each trial divisor up to
// sqrt(modulus), and the inclusion-exclusion sum takes a subset product and two divisions
// per subset of the k distinct primes (at most 511 subsets). Modulus 0 or 1 and a reversed
// range skip the divider. A reversed range sets range_error with a count of zero. The next
// item is taken as soon as the result sits in the output register.
`timescale 1ns / 1ps
module coprime_count_in_range
  import cc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // range_low, range_high, modulus, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // coprime_count, range_error, zero pad
);

  cmd_t cmd;
  sts_t sts;

  cc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* src/cc_chk.sv */
// Port checker for the coprime range counter, bound to the top level.
`timescale 1ns / 1ps
module cc_chk
  import cc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an error result carries a zero count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[VALUE_BITS] |-> out_tdata[VALUE_BITS-1:0] == '0)
    else $error("error result with nonzero count");

  // one item in flight: input closes after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // an accept with no pending result is not followed at once by a result
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind coprime_count_in_range cc_chk u_chk (.*);
